// File: design/stimulus_pattern_generator_assert.svh
// assertion macros for the stimulus pattern generator
`ifndef STIMULUS_PATTERN_GENERATOR_ASSERT_SVH
`define STIMULUS_PATTERN_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SPG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SPG_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SPG_ASSERT(label, prop, msg)
`define SPG_ASSERT_RST(label, prop, msg)
`endif

`endif

// File: design/spg_pkg.sv
// shared types and constants of the stimulus pattern generator
package spg_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned MULT_W    = 31;
   localparam int unsigned DUR_W     = 24;
   localparam int unsigned PERIOD_W  = DUR_W + 1;
   localparam int unsigned DIVISOR_W = VALUE_W + 1;
   localparam int unsigned RANGE_W   = VALUE_W + 2;
   localparam int unsigned PROD_W    = 2 * TIME_W;
   localparam int unsigned ITER_W    = $clog2(PROD_W);
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = VALUE_W + TIME_W;

   typedef enum logic [2:0] {
      MODE_CONSTANT  = 3'd0,
      MODE_PULSE     = 3'd1,
      MODE_RANDOM    = 3'd2,
      MODE_INCREMENT = 3'd3,
      MODE_PATTERN   = 3'd4
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MODE       = 3'd0,
      REG_BASE       = 3'd1,
      REG_ALT        = 3'd2,
      REG_STEP       = 3'd3,
      REG_MULTIPLIER = 3'd4,
      REG_HIGH_TIME  = 3'd5,
      REG_LOW_TIME   = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul_en;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

// File: design/spg_datapath.sv
// datapath: config registers, tick counter, multiplier, remainder unit, output word
module spg_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [spg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [spg_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [spg_pkg::REQ_DATA_W-1:0] req_tdata,   // restart, zero fill
   output logic [spg_pkg::RSP_DATA_W-1:0] rsp_tdata,   // sample_value, sample_time
   input  spg_pkg::cmd_type               cmd,
   output spg_pkg::status_type            status
);
   import spg_pkg::*;

   logic [2:0]          mode_ff;
   logic [VALUE_W-1:0]  base_ff;
   logic [VALUE_W-1:0]  alt_ff;
   logic [VALUE_W-1:0]  step_ff;
   logic [MULT_W-1:0]   mult_ff;
   logic [DUR_W-1:0]    high_ff;
   logic [DUR_W-1:0]    low_ff;

   logic [TIME_W-1:0]   tick_ff, tick_in;
   logic [TIME_W-1:0]   t_ff, t_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [ITER_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [TIME_W-1:0]   time_ff;

   logic [PERIOD_W-1:0]  period;
   logic [RANGE_W-1:0]   range;
   logic                 range_ok;
   logic                 step_ok;
   logic [TIME_W-1:0]    mul_b;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CONSTANT;
         base_ff <= '0;
         alt_ff  <= '0;
         step_ff <= VALUE_W'(1);
         mult_ff <= MULT_W'(1);
         high_ff <= DUR_W'(1);
         low_ff  <= DUR_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MODE:       mode_ff <= csr_wdata[2:0];
            REG_BASE:       base_ff <= csr_wdata[VALUE_W-1:0];
            REG_ALT:        alt_ff  <= csr_wdata[VALUE_W-1:0];
            REG_STEP:       step_ff <= csr_wdata[VALUE_W-1:0];
            REG_MULTIPLIER: mult_ff <= csr_wdata[MULT_W-1:0];
            REG_HIGH_TIME:  high_ff <= csr_wdata[DUR_W-1:0];
            REG_LOW_TIME:   low_ff  <= csr_wdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   assign period   = {1'b0, high_ff} + {1'b0, low_ff};
   assign range    = {{2{alt_ff[VALUE_W-1]}}, alt_ff} - {{2{base_ff[VALUE_W-1]}}, base_ff}
                     + RANGE_W'(1);
   assign range_ok = !range[RANGE_W-1] && (range != '0);
   assign step_ok  = !step_ff[VALUE_W-1] && (step_ff != '0);

   assign status.need_div = (mode_ff == MODE_PULSE) || (mode_ff == MODE_RANDOM)
                            || (mode_ff == MODE_PATTERN);
   assign status.div_last = (cnt_ff == {ITER_W{1'b1}});

   // tick counter
   assign t_in    = req_tdata[0] ? '0 : tick_ff;
   assign tick_in = t_in + TIME_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (cmd.accept) begin
         tick_ff <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         t_ff <= t_in;
      end
   end

   // one shared multiplier, registered
   assign mul_b = (mode_ff == MODE_RANDOM) ? {{(TIME_W-MULT_W){1'b0}}, mult_ff} : step_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(t_ff) * PROD_W'(mul_b);
      end
   end

   // restoring remainder, one dividend bit per cycle
   assign shifted = {rem_ff, dvd_ff[PROD_W-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      dvd_in = dvd_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.div_init) begin
         dvd_in = (mode_ff == MODE_RANDOM) ? prod_ff : {{(PROD_W-TIME_W){1'b0}}, t_ff};
         unique case (mode_ff)
            MODE_PULSE:  div_in = {{(DIVISOR_W-PERIOD_W){1'b0}}, period};
            MODE_RANDOM: div_in = range[DIVISOR_W-1:0];
            default:     div_in = {1'b0, step_ff};
         endcase
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
         rem_in = diff[DIVISOR_W] ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
         cnt_in = cnt_ff + ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   // sample select
   always_comb begin
      unique case (mode_ff)
         MODE_CONSTANT:  value_in = base_ff;
         MODE_PULSE:     value_in = (period != '0 && rem_ff < {{(DIVISOR_W-DUR_W){1'b0}}, high_ff})
                                    ? base_ff : alt_ff;
         MODE_RANDOM:    value_in = range_ok ? base_ff + rem_ff[VALUE_W-1:0] : base_ff;
         MODE_INCREMENT: value_in = base_ff + prod_ff[VALUE_W-1:0];
         MODE_PATTERN:   value_in = step_ok ? rem_ff[VALUE_W-1:0] : '0;
         default:        value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         value_ff <= value_in;
         time_ff  <= t_ff;
      end
   end

   assign rsp_tdata = {time_ff, value_ff};

endmodule

// File: design/spg_controller.sv
// controller: sequencing state machine and output word valid
`include "stimulus_pattern_generator_assert.svh"
module spg_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  spg_pkg::status_type status,
   output spg_pkg::cmd_type    cmd
);
   import spg_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mul_en = 1'b1;
            state_in   = status.need_div ? ST_PREP : ST_FINISH;
         end
         ST_PREP: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   `SPG_ASSERT(a_one_word_in_flight, req_tvalid && req_tready |=> !req_tready, "second word accepted while busy")
   `SPG_ASSERT(a_no_overwrite, cmd.out_load |-> !rsp_valid_ff || rsp_tready, "pending result overwritten")
   `SPG_ASSERT(a_divide_ends, state_ff == ST_DIVIDE && status.div_last |=> state_ff == ST_FINISH, "remainder pass overran")
   `SPG_ASSERT_RST(a_reset_clears, $past(reset) && !reset |-> !rsp_tvalid && req_tready, "not idle after reset")

endmodule

// File: design/stimulus_pattern_generator.sv
// top level of the stimulus pattern generator
//
// each req word is one time tick; req_tdata[0] is restart, which sets the
// tick count to zero before the tick is evaluated. each tick gives one rsp
// word: sample_value in rsp_tdata[31:0], sample_time in rsp_tdata[63:32].
// the user must write registers through csr_we / csr_addr / csr_wdata only
// while idle; the block itself does not enforce this. from accept to rsp_tvalid,
// constant and increment modes pass one registered 32x32 multiply; pulse,
// random and pattern modes add the 64-step restoring remainder unit, one bit
// per cycle. one tick is in work at a time: the next word is taken in the
// cycle after the result is loaded into the output register.
// reset clears the tick count, loads register defaults (step, multiplier,
// high and low time 1, others 0) and empties the output register.
// when rsp_tready is low the result word holds in the output register;
// a finished tick then waits for the slot and input stays stalled.
module stimulus_pattern_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [spg_pkg::REQ_DATA_W-1:0] req_tdata,   // restart, zero fill
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [spg_pkg::RSP_DATA_W-1:0] rsp_tdata,   // sample_value, sample_time
   input  logic                           csr_we,
   input  logic [spg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [spg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spg_pkg::*;

   cmd_type    cmd;
   status_type status;

   spg_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   spg_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
